>>> src/cow_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cow_pkg: shared types and helpers for the channel occupancy waterfall
// Input/result word layouts, action codes, sequencer states and the RGB565
// palette lookup.
// ----------------------------------------------------------------------------
package cow_pkg;

    // Hit count saturation level
    localparam logic [3:0] LEVEL_MAX = 4'd15;

    // Action codes carried in the input word
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_READ   = 2'd2
    } cow_act_t;

    // Input word
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] channel;
        logic       carrier;
        logic [4:0] row;
    } cow_in_t;

    // Result word
    typedef struct packed {
        logic [3:0]  level;
        logic [3:0]  peak;
        logic [15:0] color;
    } cow_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMMIT,
        ST_DRAIN
    } cow_state_t;

    // Control handed to the result stage
    typedef struct packed {
        logic load;
        logic chan_ok;
        logic cell_ok;
    } cow_rd_ctl_t;

    // RGB565 palette: red 15..11, green 10..5, blue 4..0
    function automatic logic [15:0] palette_color(input logic [3:0] lv);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        case (lv) inside
            [4'd0:4'd3]:
            begin
                r = {lv[2:0], 2'b00};
                g = 6'd0;
                b = {lv[1:0], 3'b000};
            end
            [4'd4:4'd7]:
            begin
                r = {lv[2:0], 2'b00};
                g = 6'd0;
                b = 5'd31 - {lv[1:0], 3'b000};
            end
            [4'd8:4'd11]:
            begin
                r = 5'd31;
                g = {lv[1:0], 4'b0000};
                b = 5'd0;
            end
            default:
            begin
                r = 5'd31;
                g = 6'd63;
                b = {lv[1:0], 3'b000};
            end
        endcase
        return {r, g, b};
    endfunction

endpackage

>>> src/cow_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cow_result: read result stage
// Masks the raw memory data for out-of-range cells, looks up the palette
// color and holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module cow_result
    import cow_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cow_rd_ctl_t ctl,
    input  logic [3:0]  level_raw,
    input  logic [3:0]  peak_raw,
    output logic        free,
    output logic        result_valid,
    input  logic        result_ready,
    output cow_out_t    result
);

    logic     valid_reg;
    logic     valid_next;
    cow_out_t word_reg;
    cow_out_t word_next;

    // Slot can take a new word when empty or being drained this cycle
    assign free = !valid_reg || result_ready;

    // Masked fields and color
    always_comb
    begin
        word_next.level = ctl.cell_ok ? level_raw : 4'd0;
        word_next.peak  = ctl.chan_ok ? peak_raw  : 4'd0;
        word_next.color = ctl.cell_ok ? palette_color(level_raw) : 16'd0;
        valid_next      = ctl.load ? 1'b1 : (result_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            word_reg <= word_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule

>>> src/channel_occupancy_waterfall.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_occupancy_waterfall: per-channel hit counter with sweep history
// Counts carrier hits per channel, commits sweeps into a circular history
// of rows with peak hold, and answers reads of single history cells.
// ----------------------------------------------------------------------------
// After reset the block walks every channel to clear the count/peak
// memory and takes no words meanwhile; the history memory needs no clearing
// because a fill count marks which rows have been written. Sample, read and
// unused words are taken one per cycle, back to back, unless a read waits in
// stage 1 for a full result register. A read's history data is registered
// with stage 1 and then loaded into the result register. A commit walks every
// channel through the count/peak memory, one channel a cycle, and the input is
// ready again once the sequencer has left its commit and drain states.
// ----------------------------------------------------------------------------
module channel_occupancy_waterfall
    import cow_pkg::*;
#(
    parameter int CHANNEL_COUNT = 128,
    parameter int HISTORY_ROWS  = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  cow_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output cow_out_t result
);

    localparam int CH_W       = $clog2(CHANNEL_COUNT);
    localparam int ROW_W      = $clog2(HISTORY_ROWS);
    localparam int FILL_W     = $clog2(HISTORY_ROWS + 1);
    localparam int PHYS_W     = ((ROW_W > 5) ? ROW_W : 5) + 1;
    localparam int HADDR_W    = ROW_W + CH_W;
    localparam int HIST_DEPTH = HISTORY_ROWS << CH_W;

    // Sequencer and walk
    cow_state_t        state_reg;
    cow_state_t        state_next;
    logic [CH_W-1:0]   walk_idx_reg;
    logic [CH_W-1:0]   walk_idx_next;
    logic              walk_v_reg;
    logic              walk_v_next;
    logic [CH_W-1:0]   walk_ch_reg;
    logic              walk_last;

    // History pointer and fill count
    logic [ROW_W-1:0]  ptr_reg;
    logic [ROW_W-1:0]  ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    // Stage after acceptance
    logic              s1_v_reg;
    logic              s1_v_next;
    cow_in_t           s1_item_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic              s1_chan_ok_reg;
    logic              s1_cell_ok_reg;
    logic              s1_hold;
    logic [7:0]        s1_word;

    // Write bypass for back-to-back samples
    logic              byp_v_reg;
    logic [CH_W-1:0]   byp_addr_reg;
    logic [7:0]        byp_word_reg;

    // Count/peak memory: {peak, count} per channel
    logic [7:0]        cp_mem [CHANNEL_COUNT];
    logic [7:0]        cp_rd_reg;
    logic              cp_re;
    logic [CH_W-1:0]   cp_raddr;
    logic              cp_we;
    logic [CH_W-1:0]   cp_waddr;
    logic [7:0]        cp_wdata;

    // History memory: {row, channel} addressed
    logic [3:0]        hist_mem [HIST_DEPTH];
    logic [3:0]        hist_rd_reg;
    logic              hist_re;
    logic [HADDR_W-1:0] hist_raddr;
    logic              hist_we;
    logic [HADDR_W-1:0] hist_waddr;

    // Input decode
    logic              accept;
    logic [CH_W-1:0]   item_ch;
    logic              item_chan_ok;
    logic              item_cell_ok;
    logic [PHYS_W-1:0] phys_sum;
    logic [PHYS_W-1:0] phys_row;
    logic [3:0]        walk_peak;

    logic              res_free;
    cow_rd_ctl_t       rd_ctl;

    assign accept       = item_valid && item_ready;
    assign item_ch      = CH_W'(item.channel);
    assign item_chan_ok = 32'(item.channel) < CHANNEL_COUNT;
    assign item_cell_ok = item_chan_ok && (32'(item.row) < 32'(fill_reg));
    assign walk_last    = 32'(walk_idx_reg) == (CHANNEL_COUNT - 1);

    // Newest row plus requested age, wrapped once
    assign phys_sum = PHYS_W'(ptr_reg) + PHYS_W'(item.row);
    assign phys_row = (phys_sum >= PHYS_W'(HISTORY_ROWS))
                    ? phys_sum - PHYS_W'(HISTORY_ROWS) : phys_sum;

    // A read waits in stage 1 while the result register is full
    assign s1_hold    = s1_v_reg && (s1_item_reg.action == ACT_READ) && !res_free;
    assign item_ready = (state_reg == ST_IDLE) && !s1_hold;
    assign s1_v_next  = accept || s1_hold;

    // Latest data for the stage-1 channel
    assign s1_word = (byp_v_reg && (byp_addr_reg == s1_ch_reg)) ? byp_word_reg : cp_rd_reg;
    assign walk_peak = (cp_rd_reg[3:0] > cp_rd_reg[7:4]) ? cp_rd_reg[3:0] : cp_rd_reg[7:4];

    // Sequencer: next state, walk index, pointer, fill count
    always_comb
    begin
        state_next    = state_reg;
        walk_idx_next = walk_idx_reg;
        ptr_next      = ptr_reg;
        fill_next     = fill_reg;
        walk_v_next   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                walk_idx_next = walk_idx_reg + 1'b1;
                if (walk_last)
                begin
                    walk_idx_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (item.action == ACT_COMMIT))
                begin
                    state_next    = ST_COMMIT;
                    walk_idx_next = '0;
                    ptr_next      = (ptr_reg == '0) ? ROW_W'(HISTORY_ROWS - 1)
                                                    : ptr_reg - 1'b1;
                    if (32'(fill_reg) < HISTORY_ROWS)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_COMMIT:
            begin
                walk_v_next   = 1'b1;
                walk_idx_next = walk_idx_reg + 1'b1;
                if (walk_last)
                begin
                    walk_idx_next = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory port control
    always_comb
    begin
        cp_re      = accept;
        cp_raddr   = item_ch;
        cp_we      = 1'b0;
        cp_waddr   = s1_ch_reg;
        cp_wdata   = s1_word;
        hist_re    = accept && (item.action == ACT_READ);
        hist_raddr = {phys_row[ROW_W-1:0], item_ch};
        hist_we    = 1'b0;
        hist_waddr = {ptr_reg, walk_ch_reg};

        if (state_reg == ST_COMMIT)
        begin
            cp_re    = 1'b1;
            cp_raddr = walk_idx_reg;
        end

        if (state_reg == ST_CLEAR)
        begin
            // Reset sweep: zero counts and peaks
            cp_we    = 1'b1;
            cp_waddr = walk_idx_reg;
            cp_wdata = 8'd0;
        end
        else if (walk_v_reg)
        begin
            // Commit walk: count into history, raise peak, clear count
            cp_we    = 1'b1;
            cp_waddr = walk_ch_reg;
            cp_wdata = {walk_peak, 4'd0};
            hist_we  = 1'b1;
        end
        else if (s1_v_reg && (s1_item_reg.action == ACT_SAMPLE) && s1_item_reg.carrier
                 && s1_chan_ok_reg && (s1_word[3:0] != LEVEL_MAX))
        begin
            // Carrier hit: bump the saturating count
            cp_we    = 1'b1;
            cp_waddr = s1_ch_reg;
            cp_wdata = {s1_word[7:4], s1_word[3:0] + 4'd1};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            walk_idx_reg <= '0;
            walk_v_reg   <= 1'b0;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            s1_v_reg     <= 1'b0;
            byp_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;
            walk_v_reg   <= walk_v_next;
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            s1_v_reg     <= s1_v_next;
            byp_v_reg    <= cp_we;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        walk_ch_reg  <= walk_idx_reg;
        byp_addr_reg <= cp_waddr;
        byp_word_reg <= cp_wdata;
        if (accept)
        begin
            s1_item_reg    <= item;
            s1_ch_reg      <= item_ch;
            s1_chan_ok_reg <= item_chan_ok;
            s1_cell_ok_reg <= item_cell_ok;
        end
    end

    // Count/peak memory
    always_ff @(posedge clk)
    begin
        if (cp_we)
        begin
            cp_mem[cp_waddr] <= cp_wdata;
        end
        if (cp_re)
        begin
            cp_rd_reg <= cp_mem[cp_raddr];
        end
    end

    // History memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= cp_rd_reg[3:0];
        end
        if (hist_re)
        begin
            hist_rd_reg <= hist_mem[hist_raddr];
        end
    end

    // Result stage
    always_comb
    begin
        rd_ctl.load    = s1_v_reg && (s1_item_reg.action == ACT_READ) && res_free;
        rd_ctl.chan_ok = s1_chan_ok_reg;
        rd_ctl.cell_ok = s1_cell_ok_reg;
    end

    cow_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (rd_ctl),
        .level_raw    (hist_rd_reg),
        .peak_raw     (s1_word[7:4]),
        .free         (res_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> src/cow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cow_checker: port-level checks for the channel occupancy waterfall
// Watches the input and result channels and flags ordering and value slips.
// ----------------------------------------------------------------------------
module cow_checker
    import cow_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_ready,
    input cow_in_t  item,
    input logic     result_valid,
    input logic     result_ready,
    input cow_out_t result
);

    // Stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // A fresh result comes only from a read taken ahead of it by the stage-1 and result registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(item_valid && item_ready && (item.action == ACT_READ), 2))
        else $error("result without matching read");

    // Stored level never exceeds the channel's peak hold
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.peak >= result.level)
        else $error("level above peak hold");

    // A commit stalls the input while channels are walked
    a_commit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.action == ACT_COMMIT) |=> !item_ready)
        else $error("input ready right after commit");

endmodule

bind channel_occupancy_waterfall cow_checker u_cow_checker (.*);
